[sv/bmhq_pkg.sv]
`timescale 1ns / 1ps

package bmhq_pkg;

    // Default sizing
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POLL   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic poll;
    } t_cell_ctl;

endpackage

[sv/bmhq_cell.sv]
`timescale 1ns / 1ps

// One slot of the sorted chain. Slots hold keys in ascending order from
// cell 0; empty slots sit at the tail and act as +infinity.
module bmhq_cell #(
    parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bmhq_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_new_key,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic                  i_left_vld,
    input  logic                  i_left_le,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    input  logic                  i_right_vld,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic                  o_vld,
    output logic                  o_le
);

    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_vld, n_vld;

    // Held key is no larger than the incoming one
    assign o_le  = r_vld && ($signed(r_key) <= $signed(i_new_key));
    assign o_key = r_key;
    assign o_vld = r_vld;

    // Insert: keep, take the new key, or shift in from the left.
    // Poll: shift in from the right.
    always_comb begin
        n_key = r_key;
        n_vld = r_vld;
        if (i_ctl.insert) begin
            if (!o_le) begin
                if (i_left_le) begin
                    n_key = i_new_key;
                    n_vld = 1'b1;
                end else begin
                    n_key = i_left_key;
                    n_vld = i_left_vld;
                end
            end
        end else if (i_ctl.poll) begin
            n_key = i_right_key;
            n_vld = i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[sv/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
// A result is registered when its request is accepted. Throughput: one
// request per cycle while o_stall is low; every cell compares its key with
// the incoming one in parallel and shifts by one slot, so no walk over levels.
// Reset (synchronous, active low) empties the queue and clears output valid;
// stored keys are not cleared and need no clearing pass.
module binary_min_heap_queue #(
    parameter int CAPACITY  = bmhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_func,
    input  logic signed [bmhq_pkg::VALUE_W-1:0]  i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [bmhq_pkg::VALUE_W-1:0]  o_min_value,
    output logic [bmhq_pkg::STATUS_W-1:0]    o_status,
    output logic [bmhq_pkg::COUNT_W-1:0]     o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW    = bmhq_pkg::VALUE_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                 in_acc;
    logic                 is_full, is_empty;
    bmhq_pkg::t_cell_ctl  ctl;
    logic [KEY_WIDTH-1:0] new_key;
    logic [KEY_WIDTH+VW-1:0] key_wide;
    logic [KEY_WIDTH+VW-1:0] min_wide;
    logic [CNT_W+bmhq_pkg::COUNT_W-1:0] cnt_wide;

    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]  cell_vld;
    logic [CAPACITY-1:0]  cell_le;

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_vld;
    logic [VW-1:0]        r_min, n_min;
    logic [bmhq_pkg::STATUS_W-1:0] r_status, n_status;

    // Handshake: output register parts the two sides
    assign o_stall = r_out_vld && i_stall;
    assign in_acc  = i_valid && !o_stall;

    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);

    // Key is the low KEY_WIDTH bits of the value, zero padded if wider
    assign key_wide = {{KEY_WIDTH{1'b0}}, i_value};
    assign new_key  = key_wide[KEY_WIDTH-1:0];

    // Commands to the chain only for requests that change the contents
    always_comb begin
        ctl.insert = in_acc && (i_func == bmhq_pkg::FUNC_INSERT) && !is_full;
        ctl.poll   = in_acc && (i_func == bmhq_pkg::FUNC_POLL) && !is_empty;
    end

    // Chain of cells, ascending from cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] left_key, right_key;
        logic                 left_vld, left_le, right_vld;

        if (g == 0) begin : g_head
            assign left_key = new_key;
            assign left_vld = 1'b1;
            assign left_le  = 1'b1;
        end else begin : g_mid_l
            assign left_key = cell_key[g-1];
            assign left_vld = cell_vld[g-1];
            assign left_le  = cell_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_key = cell_key[g];
            assign right_vld = 1'b0;
        end else begin : g_mid_r
            assign right_key = cell_key[g+1];
            assign right_vld = cell_vld[g+1];
        end

        bmhq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new_key   (new_key),
            .i_left_key  (left_key),
            .i_left_vld  (left_vld),
            .i_left_le   (left_le),
            .i_right_key (right_key),
            .i_right_vld (right_vld),
            .o_key       (cell_key[g]),
            .o_vld       (cell_vld[g]),
            .o_le        (cell_le[g])
        );
    end

    // Minimum sits in cell 0; report its low bits
    assign min_wide = {{VW{1'b0}}, cell_key[0]};

    // Result and count update
    always_comb begin
        n_count  = r_count;
        n_min    = '0;
        n_status = bmhq_pkg::ST_OK;
        if (i_func == bmhq_pkg::FUNC_INSERT) begin
            if (is_full) begin
                n_status = bmhq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = bmhq_pkg::ST_EMPTY;
            end else begin
                n_min   = min_wide[VW-1:0];
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_min    <= n_min;
            r_status <= n_status;
        end
    end

    assign cnt_wide    = {{bmhq_pkg::COUNT_W{1'b0}}, r_count};
    assign o_valid     = r_out_vld;
    assign o_min_value = r_min;
    assign o_status    = r_status;
    assign o_count     = cnt_wide[bmhq_pkg::COUNT_W-1:0];

    // Occupied cells match the entry count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_vld) == 32'(r_count))
        else $error("cell occupancy differs from entry count");

    // Occupied cells form a prefix from cell 0
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_vld >> 1) & ~cell_vld) == '0)
        else $error("hole in the cell chain");

    // Head holds the minimum of the first two cells
    a_head_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_vld[CAPACITY-1:1] == '0 || CAPACITY < 2 ||
        $signed(cell_key[0]) <= $signed(cell_key[1 % CAPACITY]))
        else $error("head cell is not the minimum");

    // An accepted insert with room grows the count by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.insert |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

    // Failed requests report zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status != bmhq_pkg::ST_OK) |-> r_min == '0)
        else $error("failed request reports a nonzero key");

endmodule
